FILE: rtl/sce_pkg.sv
package sce_pkg;

   localparam int KEY_W  = 64;
   localparam int TIME_W = 64;
   localparam int PAY_W  = 64;
   localparam int CODE_W = 2;

   typedef enum logic [CODE_W-1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_GET    = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_WRITE = 2'd2,
      ST_RESP  = 2'd3
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key_hi;
      logic [KEY_W-1:0]  key_lo;
      logic [TIME_W-1:0] setup_time;
      logic [PAY_W-1:0]  payload;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

FILE: rtl/sce_req_if.sv
interface sce_req_if import sce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] req_type;
   logic [KEY_W-1:0]  key_hi;
   logic [KEY_W-1:0]  key_lo;
   logic [TIME_W-1:0] setup_time;
   logic [PAY_W-1:0]  entry_payload;

   modport source (output valid, output req_type, output key_hi, output key_lo,
                   output setup_time, output entry_payload, input ready);
   modport sink   (input valid, input req_type, input key_hi, input key_lo,
                   input setup_time, input entry_payload, output ready);
endinterface

FILE: rtl/sce_rsp_if.sv
interface sce_rsp_if import sce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              status;
   logic              evicted;
   logic [TIME_W-1:0] hit_time;
   logic [PAY_W-1:0]  hit_payload;

   modport source (output valid, output status, output evicted, output hit_time,
                   output hit_payload, input ready);
   modport sink   (input valid, input status, input evicted, input hit_time,
                   input hit_payload, output ready);
endinterface

FILE: rtl/sce_ram.sv
module sce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/session_cache_oldest_evict.sv
// Session cache of CACHE_SIZE entries (128-bit key, setup time, payload word), one request at
// a time, one result word per request. The entries sit in a single-port-read RAM with a
// registered read; the valid bits are flops cleared by reset, so no clearing pass is needed.
// An add to a table with a free slot writes straight into the lowest free slot in the write
// state, then loads its result word in the result state. Remove, get, and an add to a full
// table (which evicts the oldest entry, lowest slot on a tie) read every slot in turn through
// the RAM port, and an add then writes the new entry over the evicted slot. A request code
// with no meaning answers all zero. The next request is taken as soon as the previous result
// word is loaded into the output register, even while that word still waits to be taken.
module session_cache_oldest_evict import sce_pkg::*; #(
   parameter int CACHE_SIZE = 8
) (
   input  logic       clock,
   input  logic       reset,
   sce_req_if.sink    req_bus,
   sce_rsp_if.source  rsp_bus
);

   localparam int IW = (CACHE_SIZE > 1) ? $clog2(CACHE_SIZE) : 1;
   localparam int CW = $clog2(CACHE_SIZE + 1);

   state_type         state_ff, state_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [KEY_W-1:0]  key_hi_ff, key_hi_in;
   logic [KEY_W-1:0]  key_lo_ff, key_lo_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [PAY_W-1:0]  pay_ff, pay_in;
   logic [CACHE_SIZE-1:0] valid_ff, valid_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic [IW-1:0]     slot_ff, slot_in;
   logic              evict_ff, evict_in;
   logic              found_ff, found_in;
   logic              have_ff, have_in;
   logic [TIME_W-1:0] min_time_ff, min_time_in;
   logic [TIME_W-1:0] hit_time_ff, hit_time_in;
   logic [PAY_W-1:0]  hit_pay_ff, hit_pay_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_evicted_ff, rsp_evicted_in;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;
   logic [PAY_W-1:0]  rsp_pay_ff, rsp_pay_in;

   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [IW-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type         wr_entry;
   entry_type         rd_entry;
   logic              full;
   logic [IW-1:0]     free_idx;
   logic              key_match;
   logic              last_read;

   sce_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CACHE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign wr_entry = '{key_hi: key_hi_ff, key_lo: key_lo_ff, setup_time: time_ff,
                       payload: pay_ff};
   assign rd_entry = entry_type'(ram_rd_data);

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = CACHE_SIZE - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   assign full      = &valid_ff;
   assign key_match = valid_ff[rd_idx_ff] && (rd_entry.key_hi == key_hi_ff) &&
                      (rd_entry.key_lo == key_lo_ff);
   assign last_read = rd_vld_ff && (rd_idx_ff == IW'(CACHE_SIZE - 1));

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      key_hi_in      = key_hi_ff;
      key_lo_in      = key_lo_ff;
      time_in        = time_ff;
      pay_in         = pay_ff;
      valid_in       = valid_ff;
      cnt_in         = cnt_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      slot_in        = slot_ff;
      evict_in       = evict_ff;
      found_in       = found_ff;
      have_in        = have_ff;
      min_time_in    = min_time_ff;
      hit_time_in    = hit_time_ff;
      hit_pay_in     = hit_pay_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_time_in    = rsp_time_ff;
      rsp_pay_in     = rsp_pay_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = cnt_ff[IW-1:0];
      req_bus.ready  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               code_in   = req_bus.req_type;
               key_hi_in = req_bus.key_hi;
               key_lo_in = req_bus.key_lo;
               time_in   = req_bus.setup_time;
               pay_in    = req_bus.entry_payload;
               cnt_in    = '0;
               found_in  = 1'b0;
               have_in   = 1'b0;
               evict_in  = 1'b0;
               case (req_bus.req_type)
                  REQ_ADD: begin
                     if (full) begin
                        state_in = ST_SCAN;
                     end else begin
                        slot_in  = free_idx;
                        state_in = ST_WRITE;
                     end
                  end
                  REQ_REMOVE, REQ_GET: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (cnt_ff < CW'(CACHE_SIZE)) begin
               ram_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[IW-1:0];
               cnt_in    = cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               case (code_ff)
                  REQ_ADD: begin
                     if (!have_ff || (rd_entry.setup_time < min_time_ff)) begin
                        have_in     = 1'b1;
                        min_time_in = rd_entry.setup_time;
                        slot_in     = rd_idx_ff;
                     end
                  end
                  REQ_REMOVE: begin
                     if (key_match) begin
                        valid_in[rd_idx_ff] = 1'b0;
                     end
                  end
                  REQ_GET: begin
                     if (key_match && !found_ff) begin
                        found_in    = 1'b1;
                        hit_time_in = rd_entry.setup_time;
                        hit_pay_in  = rd_entry.payload;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (last_read) begin
               if (code_ff == REQ_ADD) begin
                  evict_in = 1'b1;
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_WRITE: begin
            ram_wr_en          = 1'b1;
            valid_in[slot_ff]  = 1'b1;
            state_in           = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = (code_ff == REQ_GET) && !found_ff;
               rsp_evicted_in = evict_ff;
               rsp_time_in    = ((code_ff == REQ_GET) && found_ff) ? hit_time_ff : '0;
               rsp_pay_in     = ((code_ff == REQ_GET) && found_ff) ? hit_pay_ff : '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff        <= code_in;
      key_hi_ff      <= key_hi_in;
      key_lo_ff      <= key_lo_in;
      time_ff        <= time_in;
      pay_ff         <= pay_in;
      cnt_ff         <= cnt_in;
      rd_idx_ff      <= rd_idx_in;
      slot_ff        <= slot_in;
      evict_ff       <= evict_in;
      found_ff       <= found_in;
      have_ff        <= have_in;
      min_time_ff    <= min_time_in;
      hit_time_ff    <= hit_time_in;
      hit_pay_ff     <= hit_pay_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_time_ff    <= rsp_time_in;
      rsp_pay_ff     <= rsp_pay_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.evicted     = rsp_evicted_ff;
   assign rsp_bus.hit_time    = rsp_time_ff;
   assign rsp_bus.hit_payload = rsp_pay_ff;

endmodule

FILE: rtl/sce_check.sv
module sce_check import sce_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_status,
   input logic              rsp_evicted,
   input logic [TIME_W-1:0] rsp_hit_time,
   input logic [PAY_W-1:0]  rsp_hit_payload
);

   // one request in the works at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one in flight");

   a_miss_is_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (!rsp_evicted && (rsp_hit_time == '0) &&
                                     (rsp_hit_payload == '0)))
      else $error("miss word carries data");

   a_evict_is_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> (!rsp_status && (rsp_hit_time == '0) &&
                                      (rsp_hit_payload == '0)))
      else $error("eviction word carries hit data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
                                     $stable(rsp_evicted) && $stable(rsp_hit_time) &&
                                     $stable(rsp_hit_payload)))
      else $error("stalled result word changed");

endmodule

bind session_cache_oldest_evict sce_check u_sce_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_evicted     (rsp_bus.evicted),
   .rsp_hit_time    (rsp_bus.hit_time),
   .rsp_hit_payload (rsp_bus.hit_payload)
);

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sce_pkg::*;

   localparam int                CACHE_SIZE = 8;
   localparam logic [CODE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int                KEY_POOL   = 16;
   localparam int                HOLDOFF    = 400;

   typedef struct {
      logic [CODE_W-1:0] code;
      logic [KEY_W-1:0]  key_hi;
      logic [KEY_W-1:0]  key_lo;
      logic [TIME_W-1:0] stamp;
      logic [PAY_W-1:0]  payload;
   } request_type;

   typedef struct packed {
      logic              status;
      logic              evicted;
      logic [TIME_W-1:0] hit_time;
      logic [PAY_W-1:0]  hit_payload;
   } reply_type;

   logic clock;
   logic reset;

   sce_req_if req_bus ();
   sce_rsp_if rsp_bus ();

   session_cache_oldest_evict #(.CACHE_SIZE(CACHE_SIZE)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow copy of the table
   bit                slot_valid   [CACHE_SIZE];
   logic [KEY_W-1:0]  slot_key_hi  [CACHE_SIZE];
   logic [KEY_W-1:0]  slot_key_lo  [CACHE_SIZE];
   logic [TIME_W-1:0] slot_time    [CACHE_SIZE];
   logic [PAY_W-1:0]  slot_payload [CACHE_SIZE];

   reply_type cache_replies_due[$];
   logic [2*KEY_W-1:0] key_pool[KEY_POOL];

   int errors      = 0;
   int replies_in  = 0;
   int n_add       = 0;
   int n_evict     = 0;
   int n_remove    = 0;
   int n_get       = 0;
   int n_hit       = 0;
   int n_unused    = 0;

   int          burst_left   = 0;
   bit          pacing_on    = 1'b0;
   int          holdoff_left = 0;
   int          pattern_age  = 0;
   logic [15:0] stall_pattern = '1;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit slot_matches(int s, logic [KEY_W-1:0] hi, logic [KEY_W-1:0] lo);
      return slot_valid[s] && slot_key_hi[s] == hi && slot_key_lo[s] == lo;
   endfunction

   function automatic reply_type compute_cache_reply(request_type rq);
      reply_type r;
      int        slot;
      bit        found;
      r     = '0;
      slot  = -1;
      found = 1'b0;
      case (rq.code)
         REQ_ADD: begin
            n_add++;
            for (int s = 0; s < CACHE_SIZE; s++)
               if (!slot_valid[s] && slot < 0) slot = s;
            if (slot < 0) begin
               slot = 0;
               for (int s = 1; s < CACHE_SIZE; s++)
                  if (slot_time[s] < slot_time[slot]) slot = s;
               r.evicted = 1'b1;
               n_evict++;
            end
            slot_valid[slot]   = 1'b1;
            slot_key_hi[slot]  = rq.key_hi;
            slot_key_lo[slot]  = rq.key_lo;
            slot_time[slot]    = rq.stamp;
            slot_payload[slot] = rq.payload;
         end
         REQ_REMOVE: begin
            n_remove++;
            for (int s = 0; s < CACHE_SIZE; s++)
               if (slot_matches(s, rq.key_hi, rq.key_lo)) slot_valid[s] = 1'b0;
         end
         REQ_GET: begin
            n_get++;
            r.status = 1'b1;
            for (int s = 0; s < CACHE_SIZE; s++) begin
               if (!found && slot_matches(s, rq.key_hi, rq.key_lo)) begin
                  found         = 1'b1;
                  r.status      = 1'b0;
                  r.hit_time    = slot_time[s];
                  r.hit_payload = slot_payload[s];
               end
            end
            if (found) n_hit++;
         end
         default: begin
            n_unused++;
         end
      endcase
      return r;
   endfunction

   // offer one word, wait for it to be taken, then idle between bursts when pacing is on
   task automatic send_request(request_type rq);
      req_bus.req_type      = rq.code;
      req_bus.key_hi        = rq.key_hi;
      req_bus.key_lo        = rq.key_lo;
      req_bus.setup_time    = rq.stamp;
      req_bus.entry_payload = rq.payload;
      req_bus.valid         = 1'b1;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      cache_replies_due.push_back(compute_cache_reply(rq));
      @(negedge clock);
      req_bus.valid = 1'b0;
      if (burst_left > 0) begin
         burst_left--;
      end else if (pacing_on) begin
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   task automatic send_op(logic [CODE_W-1:0] code, logic [KEY_W-1:0] hi, logic [KEY_W-1:0] lo,
                          logic [TIME_W-1:0] stamp, logic [PAY_W-1:0] payload);
      request_type rq;
      rq.code    = code;
      rq.key_hi  = hi;
      rq.key_lo  = lo;
      rq.stamp   = stamp;
      rq.payload = payload;
      send_request(rq);
   endtask

   function automatic request_type random_request();
      request_type rq;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      rq.code = REQ_ADD;
      else if (pick < 60) rq.code = REQ_REMOVE;
      else if (pick < 95) rq.code = REQ_GET;
      else                rq.code = REQ_UNUSED;
      if ($urandom_range(0, 9) == 0) {rq.key_hi, rq.key_lo} = {rand64(), rand64()};
      else {rq.key_hi, rq.key_lo} = key_pool[$urandom_range(0, KEY_POOL - 1)];
      case ($urandom_range(0, 9))
         0:       rq.stamp = '0;
         1:       rq.stamp = '1;
         2, 3:    rq.stamp = TIME_W'($urandom_range(0, 3));
         default: rq.stamp = rand64();
      endcase
      rq.payload = rand64();
      return rq;
   endfunction

   task automatic test_basic_ops();
      logic [KEY_W-1:0] a_hi;
      logic [KEY_W-1:0] a_lo;
      a_hi = rand64();
      a_lo = rand64();
      send_op(REQ_GET, a_hi, a_lo, rand64(), rand64());
      send_op(REQ_ADD, a_hi, a_lo, '0, '1);
      send_op(REQ_ADD, '1, '1, '1, '0);
      send_op(REQ_ADD, '0, '0, '1, rand64());
      send_op(REQ_GET, a_hi, a_lo, '0, '0);
      send_op(REQ_GET, '1, '1, '0, '0);
      send_op(REQ_GET, '0, '0, '1, '1);
      send_op(REQ_REMOVE, a_hi, a_lo, '1, '1);
      send_op(REQ_GET, a_hi, a_lo, '0, '0);
      send_op(REQ_REMOVE, rand64(), rand64(), '0, '0);
   endtask

   task automatic test_duplicate_keys();
      logic [KEY_W-1:0] k_hi;
      logic [KEY_W-1:0] k_lo;
      k_hi = rand64();
      k_lo = rand64();
      send_op(REQ_ADD, k_hi, k_lo, rand64(), rand64());
      send_op(REQ_ADD, k_hi, k_lo, rand64(), rand64());
      send_op(REQ_GET, k_hi, k_lo, '0, '0);
      send_op(REQ_REMOVE, k_hi, k_lo, '0, '0);
      send_op(REQ_GET, k_hi, k_lo, '0, '0);
   endtask

   // fill with maximum timestamps so the tie goes to the lowest slot
   task automatic test_full_table_eviction();
      logic [KEY_W-1:0] first_hi;
      logic [KEY_W-1:0] first_lo;
      first_hi = rand64();
      first_lo = rand64();
      send_op(REQ_ADD, first_hi, first_lo, '1, rand64());
      repeat (5) send_op(REQ_ADD, rand64(), rand64(), '1, rand64());
      send_op(REQ_ADD, rand64(), rand64(), '1, rand64());
      send_op(REQ_GET, first_hi, first_lo, '0, '0);
   endtask

   task automatic test_unused_code();
      send_op(REQ_UNUSED, rand64(), rand64(), rand64(), rand64());
   endtask

   task automatic test_random_traffic(int n);
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {rand64(), rand64()};
      pacing_on  = 1'b1;
      burst_left = 0;
      for (int i = 0; i < n; i++) begin
         if (i % 200 == 199) key_pool[$urandom_range(0, KEY_POOL - 1)] = {rand64(), rand64()};
         send_request(random_request());
      end
      pacing_on = 1'b0;
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_output_backpressure();
      pacing_on    = 1'b0;
      holdoff_left = HOLDOFF;
      repeat (30) send_request(random_request());
   endtask

   // receiver stall pattern, replaced when pattern_age runs out
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_bus.ready = 1'b0;
         holdoff_left--;
      end else begin
         if (pattern_age == 0) begin
            if ($urandom_range(0, 2) == 0) stall_pattern = '1;
            else stall_pattern = 16'($urandom) | 16'h1;
            pattern_age = 64;
         end
         rsp_bus.ready = stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         pattern_age--;
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         replies_in++;
         if (cache_replies_due.size() == 0) begin
            errors++;
            $display("%0t: reply with nothing expected, got status %b evicted %b", $time,
                     rsp_bus.status, rsp_bus.evicted);
         end else begin
            want = cache_replies_due.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_bus.status));
            check_field("evicted", 64'(want.evicted), 64'(rsp_bus.evicted));
            check_field("hit_time", want.hit_time, rsp_bus.hit_time);
            check_field("hit_payload", want.hit_payload, rsp_bus.hit_payload);
         end
      end
   end

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.req_type      = REQ_ADD;
      req_bus.key_hi        = '0;
      req_bus.key_lo        = '0;
      req_bus.setup_time    = '0;
      req_bus.entry_payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_duplicate_keys();
      test_full_table_eviction();
      test_unused_code();
      test_random_traffic(720);
      test_output_backpressure();

      wait (cache_replies_due.size() == 0);
      repeat (40) @(negedge clock);
      if (cache_replies_due.size() != 0) begin
         errors++;
         $display("%0t: %0d replies still outstanding", $time, cache_replies_due.size());
      end
      $display("covered %0d adds (%0d with eviction), %0d removes, %0d gets (%0d hits),",
               n_add, n_evict, n_remove, n_get, n_hit);
      $display("%0d unused codes, %0d replies checked, %0d mismatches",
               n_unused, replies_in, errors);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #1ms;
      $display("timeout with %0d replies outstanding", cache_replies_due.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sce_pkg.sv
rtl/sce_req_if.sv
rtl/sce_rsp_if.sv
rtl/sce_ram.sv
rtl/session_cache_oldest_evict.sv
rtl/sce_check.sv
tb/testbench.sv
